[rtl/btfr_pkg.sv]
// shared types and constants for the battery telemetry frame receiver
`timescale 1ns / 1ps
package btfr_pkg;

  localparam int FRAME_LENGTH = 5;

  // opcodes of an input word
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_UNDERVOLT = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_MIN_CELL = 3'd0;
  localparam logic [2:0] REG_MAX_CELL = 3'd1;
  localparam logic [2:0] REG_NOM_CELL = 3'd2;
  localparam logic [2:0] REG_MIN_PACK = 3'd3;
  localparam logic [2:0] REG_MAX_PACK = 3'd4;
  localparam logic [2:0] REG_NOM_PACK = 3'd5;
  localparam logic [2:0] REG_MAX_TEMP = 3'd6;

  localparam logic [15:0] MIN_CELL_RESET = 16'd2800;
  localparam logic [15:0] MAX_CELL_RESET = 16'd3650;
  localparam logic [15:0] CELL_RESET = 16'd3300;
  localparam logic [15:0] MIN_PACK_RESET = 16'd40000;
  localparam logic [15:0] MAX_PACK_RESET = 16'd58400;
  localparam logic [15:0] PACK_RESET = 16'd48000;
  localparam logic [7:0] MAX_TEMP_RESET = 8'd60;
  localparam logic [7:0] ROOM_TEMP = 8'd20;

  localparam logic [7:0] IDLE_GAP = 8'd5;
  localparam logic [7:0] IDLE_SAVE = 8'd2;
  localparam logic [7:0] IDLE_MAX = 8'd250;
  localparam logic [15:0] MOVING_SPEED = 16'd10;

  // reciprocal scaling for the divide by history depth
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W = RECIP_SHIFT + 1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [15:0] motor_speed;
  } in_t;

  typedef struct packed {
    logic [7:0]  temperature_out;
    logic [15:0] cell_voltage_out;
    logic [15:0] pack_voltage_out;
    logic        undervoltage_latched;
  } out_t;

  // one history entry, also used for the averages
  typedef struct packed {
    logic [7:0]  temp;
    logic [15:0] cell_v;
    logic [15:0] pack;
  } hist_t;

endpackage

[rtl/btfr_avg.sv]
// history ring and sequential averaging unit with one shared multiplier
`timescale 1ns / 1ps
module btfr_avg #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  btfr_pkg::hist_t  frame,
  output logic             done,
  output btfr_pkg::hist_t  avg
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam int RECIP_INT =
    ((1 << btfr_pkg::RECIP_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam logic [btfr_pkg::RECIP_W-1:0] RECIP = btfr_pkg::RECIP_W'(RECIP_INT);
  localparam int PROD_W = 16 + btfr_pkg::RECIP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  localparam logic [1:0] F_TEMP = 2'd0;
  localparam logic [1:0] F_CELL = 2'd1;
  localparam logic [1:0] F_PACK = 2'd2;

  btfr_pkg::hist_t   hist [HISTORY_DEPTH];
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  k;
  logic [1:0]        fsel;
  logic [1:0]        state;
  logic [PROD_W-1:0] prod;
  logic [1:0]        prod_fsel;
  logic              prod_valid;
  btfr_pkg::hist_t   acc;
  btfr_pkg::hist_t   acc_next;
  logic [15:0]       operand;
  logic [15:0]       quot;

  always_comb begin
    case (fsel)
      F_TEMP:  operand = {8'd0, hist[k].temp};
      F_CELL:  operand = hist[k].cell_v;
      F_PACK:  operand = hist[k].pack;
      default: operand = 16'd0;
    endcase
  end

  assign quot = prod[btfr_pkg::RECIP_SHIFT +: 16];

  always_comb begin
    acc_next = acc;
    if (prod_valid) begin
      case (prod_fsel)
        F_TEMP:  acc_next.temp = acc.temp + quot[7:0];
        F_CELL:  acc_next.cell_v = acc.cell_v + quot;
        F_PACK:  acc_next.pack = acc.pack + quot;
        default: acc_next = acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
      ptr <= '0;
      state <= S_IDLE;
      prod_valid <= 1'b0;
      done <= 1'b0;
      avg <= '{temp: btfr_pkg::ROOM_TEMP, cell_v: btfr_pkg::CELL_RESET,
               pack: btfr_pkg::PACK_RESET};
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          prod_valid <= 1'b0;
          if (start) begin
            hist[ptr] <= frame;
            ptr <= (ptr == LAST) ? '0 : ptr + 1'b1;
            k <= '0;
            fsel <= F_TEMP;
            acc <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          // multiply by the scaled reciprocal, add last cycle's quotient
          prod <= PROD_W'(operand) * PROD_W'(RECIP);
          prod_fsel <= fsel;
          prod_valid <= 1'b1;
          acc <= acc_next;
          if (fsel == F_PACK) begin
            fsel <= F_TEMP;
            if (k == LAST) begin
              state <= S_DRAIN;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            fsel <= fsel + 1'b1;
          end
        end
        S_DRAIN: begin
          avg <= acc_next;
          prod_valid <= 1'b0;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/battery_telemetry_frame_receiver_top.sv]
// top level of the battery telemetry frame receiver
`timescale 1ns / 1ps
// Takes one input word per handshake on the item channel: a received uart
// byte, a timer tick, or an undervoltage edge with the current motor speed.
// Bytes build 5-byte frames separated by idle ticks; on the second idle tick
// the last frame goes into a HISTORY_DEPTH-deep history ring and the averages
// are recomputed. Every input word gives exactly one result word on the
// result channel: the averages after range checks, plus the latched
// undervoltage flag.
// One word at a time: a byte, an undervoltage edge or a plain tick goes from
// the accept to the emit state, which loads the result register, and the next
// word is taken once the block is back in idle. A tick that stores a frame
// goes first to the wait state until the averaging sequencer is done; the
// sequencer walks the ring and runs each entry's three values through one
// reciprocal multiplier.
// item_ready is high only while the block waits for a word. If the result
// receiver stalls, the finished result waits in the output register, and the
// next word is still taken; its result holds until the register frees.
// Reset clears the history ring, the frame state and the flag, restores the
// averages and thresholds to their defaults, and leaves the result empty.
// Write thresholds via the apb port only while the block is idle (unenforced).
module battery_telemetry_frame_receiver_top #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  btfr_pkg::in_t    item,
  output logic             result_valid,
  input  logic             result_ready,
  output btfr_pkg::out_t   result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  state;
  logic        started;
  logic [7:0]  idle_ticks;
  logic [7:0]  idle_next;
  logic [2:0]  byte_index;
  logic [7:0]  rx_buf [btfr_pkg::FRAME_LENGTH];
  logic [7:0]  frame_bytes [btfr_pkg::FRAME_LENGTH];
  logic        uv_flag;
  logic        avg_start;
  logic        avg_done;
  logic        take_byte;
  logic        accept;
  logic        load_out;
  btfr_pkg::hist_t frame;
  btfr_pkg::hist_t avg;
  btfr_pkg::out_t  result_next;

  logic [15:0] min_cell_mv;
  logic [15:0] max_cell_mv;
  logic [15:0] nominal_cell_mv;
  logic [15:0] min_pack_voltage;
  logic [15:0] max_pack_voltage;
  logic [15:0] nominal_pack_voltage;
  logic [7:0]  max_temperature;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cell_mv <= btfr_pkg::MIN_CELL_RESET;
      max_cell_mv <= btfr_pkg::MAX_CELL_RESET;
      nominal_cell_mv <= btfr_pkg::CELL_RESET;
      min_pack_voltage <= btfr_pkg::MIN_PACK_RESET;
      max_pack_voltage <= btfr_pkg::MAX_PACK_RESET;
      nominal_pack_voltage <= btfr_pkg::PACK_RESET;
      max_temperature <= btfr_pkg::MAX_TEMP_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        btfr_pkg::REG_MIN_CELL: min_cell_mv <= pwdata[15:0];
        btfr_pkg::REG_MAX_CELL: max_cell_mv <= pwdata[15:0];
        btfr_pkg::REG_NOM_CELL: nominal_cell_mv <= pwdata[15:0];
        btfr_pkg::REG_MIN_PACK: min_pack_voltage <= pwdata[15:0];
        btfr_pkg::REG_MAX_PACK: max_pack_voltage <= pwdata[15:0];
        btfr_pkg::REG_NOM_PACK: nominal_pack_voltage <= pwdata[15:0];
        btfr_pkg::REG_MAX_TEMP: max_temperature <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      btfr_pkg::REG_MIN_CELL: prdata = {16'd0, min_cell_mv};
      btfr_pkg::REG_MAX_CELL: prdata = {16'd0, max_cell_mv};
      btfr_pkg::REG_NOM_CELL: prdata = {16'd0, nominal_cell_mv};
      btfr_pkg::REG_MIN_PACK: prdata = {16'd0, min_pack_voltage};
      btfr_pkg::REG_MAX_PACK: prdata = {16'd0, max_pack_voltage};
      btfr_pkg::REG_NOM_PACK: prdata = {16'd0, nominal_pack_voltage};
      btfr_pkg::REG_MAX_TEMP: prdata = {24'd0, max_temperature};
      default:                prdata = 32'd0;
    endcase
  end

  // frame receive
  assign item_ready = (state == ST_IDLE);
  assign accept = item_valid && item_ready;
  assign take_byte = (byte_index != 3'd0) ||
                     (started && (idle_ticks >= btfr_pkg::IDLE_GAP));
  assign idle_next = (idle_ticks < btfr_pkg::IDLE_MAX) ? idle_ticks + 8'd1 : idle_ticks;

  assign frame = '{temp: frame_bytes[0],
                   cell_v: {frame_bytes[2], frame_bytes[1]},
                   pack: {frame_bytes[4], frame_bytes[3]}};

  always_ff @(posedge clk) begin
    if (accept && (item.opcode == btfr_pkg::OP_BYTE) && take_byte &&
        (byte_index < 3'(btfr_pkg::FRAME_LENGTH))) begin
      rx_buf[byte_index] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      started <= 1'b0;
      idle_ticks <= 8'd0;
      byte_index <= 3'd0;
      uv_flag <= 1'b0;
      avg_start <= 1'b0;
      for (int i = 0; i < btfr_pkg::FRAME_LENGTH; i++) begin
        frame_bytes[i] <= 8'd0;
      end
    end else begin
      avg_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EMIT;
            case (item.opcode)
              btfr_pkg::OP_BYTE: begin
                if (take_byte) begin
                  idle_ticks <= 8'd0;
                  if (byte_index < 3'(btfr_pkg::FRAME_LENGTH)) begin
                    // last byte completes the frame
                    if (byte_index == 3'(btfr_pkg::FRAME_LENGTH - 1)) begin
                      for (int i = 0; i < btfr_pkg::FRAME_LENGTH - 1; i++) begin
                        frame_bytes[i] <= rx_buf[i];
                      end
                      frame_bytes[btfr_pkg::FRAME_LENGTH-1] <= item.rx_byte;
                    end
                    byte_index <= byte_index + 3'd1;
                  end
                end
              end
              btfr_pkg::OP_TICK: begin
                started <= 1'b1;
                byte_index <= 3'd0;
                idle_ticks <= idle_next;
                if (idle_next == btfr_pkg::IDLE_SAVE) begin
                  avg_start <= 1'b1;
                  state <= ST_WAIT;
                end
              end
              btfr_pkg::OP_UNDERVOLT: begin
                if (item.motor_speed >= btfr_pkg::MOVING_SPEED) begin
                  uv_flag <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WAIT: begin
          if (avg_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  btfr_avg #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_avg (
    .clk   (clk),
    .rst   (rst),
    .start (avg_start),
    .frame (frame),
    .done  (avg_done),
    .avg   (avg)
  );

  // range checks with fallbacks
  always_comb begin
    result_next.temperature_out =
      (avg.temp <= max_temperature) ? avg.temp : btfr_pkg::ROOM_TEMP;
    result_next.cell_voltage_out =
      (avg.cell_v >= min_cell_mv && avg.cell_v <= max_cell_mv) ? avg.cell_v : nominal_cell_mv;
    result_next.pack_voltage_out =
      (avg.pack >= min_pack_voltage && avg.pack <= max_pack_voltage) ?
      avg.pack : nominal_pack_voltage;
    result_next.undervoltage_latched = uv_flag;
  end

  assign load_out = (state == ST_EMIT) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= result_next;
    end
  end

endmodule

[rtl/btfr_checker.sv]
// port-level checks for the battery telemetry frame receiver
`timescale 1ns / 1ps
module btfr_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input logic           result_valid,
  input logic           result_ready,
  input btfr_pkg::out_t result
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken again before the previous word finished");

  // undervoltage flag is sticky
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.undervoltage_latched |=>
      !result_valid || result.undervoltage_latched)
    else $error("undervoltage flag dropped without reset");

endmodule

bind battery_telemetry_frame_receiver_top btfr_checker u_btfr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
